FILE: src/gsfc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the gas sensor frame checker.
package gsfc_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FIRST_BAD  = 2'd1;
    localparam logic [1:0] STATUS_SECOND_BAD = 2'd2;

    localparam logic [2:0] POS_W0_HI  = 3'd0;
    localparam logic [2:0] POS_W0_LO  = 3'd1;
    localparam logic [2:0] POS_W0_CRC = 3'd2;
    localparam logic [2:0] POS_W1_HI  = 3'd3;
    localparam logic [2:0] POS_W1_LO  = 3'd4;
    localparam logic [2:0] POS_W1_CRC = 3'd5;

    typedef struct packed {
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [1:0]  frame_status;
        logic        sensor_ready;
    } frame_result_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: src/gsfc_frame_parser.sv
// Byte position tracking, per-word CRC check and word assembly for one reply frame.
module gsfc_frame_parser
    import gsfc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          byte_en,
    input  logic [7:0]    rx_byte,
    input  logic          frame_start,
    output logic          frame_done,
    output frame_result_t frame_result
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] second_reg, second_next;
    logic [1:0]  err_reg, err_next;
    logic        ready_reg, ready_next;
    logic [2:0]  pos;
    logic [7:0]  crc_upd;

    always_comb begin
        pos = pos_reg;
        if (frame_start || pos_reg > POS_W1_CRC) begin
            pos = POS_W0_HI;
        end
        crc_upd     = crc8_byte(crc_reg, rx_byte);
        pos_next    = pos + 3'd1;
        crc_next    = crc_reg;
        high_next   = high_reg;
        first_next  = first_reg;
        second_next = second_reg;
        err_next    = err_reg;
        ready_next  = ready_reg;
        frame_done  = 1'b0;

        unique case (pos) inside
            POS_W0_HI, POS_W1_HI: begin
                crc_next  = crc8_byte(CRC_INIT, rx_byte);
                high_next = rx_byte;
                if (pos == POS_W0_HI) begin
                    err_next = STATUS_OK;
                end
            end
            POS_W0_LO: begin
                crc_next   = crc_upd;
                first_next = {high_reg, rx_byte};
            end
            POS_W1_LO: begin
                crc_next    = crc_upd;
                second_next = {high_reg, rx_byte};
            end
            POS_W0_CRC: begin
                if (crc_reg != rx_byte) begin
                    err_next = STATUS_FIRST_BAD;
                end
                crc_next = CRC_INIT;
            end
            default: begin
                if (err_reg == STATUS_OK && crc_reg != rx_byte) begin
                    err_next = STATUS_SECOND_BAD;
                end
                if (err_next == STATUS_OK && second_reg != 16'd0) begin
                    ready_next = 1'b1;
                end
                pos_next   = POS_W0_HI;
                crc_next   = CRC_INIT;
                frame_done = 1'b1;
            end
        endcase

        frame_result.first_word   = first_reg;
        frame_result.second_word  = second_reg;
        frame_result.frame_status = err_next;
        frame_result.sensor_ready = ready_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_W0_HI;
            crc_reg    <= CRC_INIT;
            high_reg   <= 8'd0;
            first_reg  <= 16'd0;
            second_reg <= 16'd0;
            err_reg    <= STATUS_OK;
            ready_reg  <= 1'b0;
        end else if (byte_en) begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            high_reg   <= high_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            err_reg    <= err_next;
            ready_reg  <= ready_next;
        end
    end

endmodule

FILE: src/gas_sensor_frame_checker.sv
// Top level of the gas sensor reply frame checker with its result register.
// The block takes one reply byte per beat and accepts a new byte in every cycle
// while the result register is empty or being drained. Each word is two data
// bytes, high first, and a CRC-8 byte (polynomial 0x31, initial value 0xFF,
// MSB first); the sixth byte of a frame yields one result beat in the next
// cycle carrying both words, the status of the first failing word, and the
// sticky sensor ready flag. A byte with s_frame_start high always opens a new
// frame and drops any partial one. The input stalls only while a result beat
// waits on m_ready.
module gas_sensor_frame_checker
    import gsfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_first_word,
    output logic [15:0] m_second_word,
    output logic [1:0]  m_frame_status,
    output logic        m_sensor_ready
);

    logic          byte_en;
    logic          frame_done;
    frame_result_t frame_result;
    logic          m_valid_reg;
    frame_result_t result_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign byte_en = s_valid && s_ready;

    gsfc_frame_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_en      (byte_en),
        .rx_byte      (s_rx_byte),
        .frame_start  (s_frame_start),
        .frame_done   (frame_done),
        .frame_result (frame_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            result_reg  <= '0;
        end else begin
            if (byte_en && frame_done) begin
                m_valid_reg <= 1'b1;
                result_reg  <= frame_result;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_first_word   = result_reg.first_word;
    assign m_second_word  = result_reg.second_word;
    assign m_frame_status = result_reg.frame_status;
    assign m_sensor_ready = result_reg.sensor_ready;

endmodule

FILE: src/gsfc_checker.sv
// Port-level assertions for the gas sensor frame checker and their bind.
module gsfc_checker
    import gsfc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_second_word,
    input logic [1:0]  m_frame_status,
    input logic        m_sensor_ready
);

    // A result beat stays valid until it is taken.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped before it was taken");

    a_in_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frame_status <= STATUS_SECOND_BAD)
        else $error("undefined frame status");

    a_ready_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(m_sensor_ready))
        else $error("sensor ready flag cleared");

    a_ready_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_status == STATUS_OK && m_second_word != 16'd0
            |-> m_sensor_ready)
        else $error("good frame with nonzero second word left ready low");

endmodule

bind gas_sensor_frame_checker gsfc_checker u_gsfc_checker (.*);
